### rtl/core/assert_macros.svh
// Assertion macros shared by the unpacker RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock outside reset
`define PFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be true outside reset
`define PFU_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

### rtl/core/pfu_pkg.sv
// Types and constants of the packed field unpacker.
// No dependencies; used by every module of the block.
package pfu_pkg;

  localparam int unsigned MAX_COLUMNS = 4;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    MODE_BIT1  = 2'd0,
    MODE_BIT2  = 2'd1,
    MODE_BIT4  = 2'd2,
    MODE_FIELD = 2'd3
  } mode_t;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_COLCNT  = 3'd1;
  localparam logic [2:0] REG_WIDTH0  = 3'd2;
  localparam logic [2:0] REG_WIDTH1  = 3'd3;
  localparam logic [2:0] REG_WIDTH2  = 3'd4;
  localparam logic [2:0] REG_WIDTH3  = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  column;
    logic        last_of_item;
  } out_t;

  // one classified byte, handed from front to back
  typedef struct packed {
    mode_t           mode;
    logic [7:0]      data;
    logic [1:0]      nzero;
    logic [2:0][1:0] zcol;
    logic            has_field;
    logic [63:0]     field_val;
    logic [1:0]      field_col;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/pfu_front.sv
// Front end: configuration registers, field state and byte classification.
// Depends on pfu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [3:0]       cfg_wdata,
  input  logic             in_valid,
  input  pfu_pkg::in_t     in_data,
  output logic             in_stall,
  input  pfu_pkg::q_stat_t q_stat,
  output logic             q_push,
  output pfu_pkg::job_t    q_job
);
  import pfu_pkg::*;

  mode_t       mode_r;
  logic [2:0]  colcnt_r;
  logic [3:0]  width0_r, width1_r, width2_r, width3_r;
  logic [63:0] partial_r;
  logic [2:0]  bt_r;
  logic [1:0]  col_r;

  logic        in_acc;
  logic [2:0]  cnt;
  logic [3:0]  nz;
  logic [3:0]  act;
  logic        any;
  logic [1:0]  c0, cur;
  logic [1:0]  nzero;
  logic [2:0][1:0] zcol;
  logic        stop;
  logic [3:0]  wraw, wcur, taken;
  logic        has_field;
  logic        need_push;
  logic        eob_acc;
  logic        state_clr;

  function automatic logic [1:0] col_next(logic [1:0] c, logic [2:0] n);
    logic [2:0] s;
    s = {1'b0, c} + 3'd1;
    return (s >= n) ? 2'd0 : s[1:0];
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = q_stat.full;

  always_comb begin
    if (colcnt_r == 3'd0) cnt = 3'd1;
    else if (colcnt_r > 3'(MAX_COLUMNS)) cnt = 3'(MAX_COLUMNS);
    else cnt = colcnt_r;
    nz = {width3_r != 4'd0, width2_r != 4'd0, width1_r != 4'd0, width0_r != 4'd0};
    for (int i = 0; i < 4; i++) act[i] = (3'(i) < cnt);
    any = |(nz & act);
    c0  = ({1'b0, col_r} >= cnt) ? 2'd0 : col_r;

    // walk past zero-width columns; at most three when some width is nonzero
    cur   = c0;
    nzero = 2'd0;
    zcol  = '0;
    stop  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!stop && !nz[cur]) begin
        zcol[i] = cur;
        nzero   = nzero + 2'd1;
        cur     = col_next(cur, cnt);
      end else begin
        stop = 1'b1;
      end
    end

    case (cur)
      2'd0:    wraw = width0_r;
      2'd1:    wraw = width1_r;
      2'd2:    wraw = width2_r;
      default: wraw = width3_r;
    endcase
    wcur      = (wraw > 4'd8) ? 4'd8 : wraw;
    taken     = {1'b0, bt_r} + 4'd1;
    has_field = (taken >= wcur);

    if (mode_r != MODE_FIELD) need_push = 1'b1;
    else need_push = any && (nzero != 2'd0 || has_field);
  end

  assign q_push = in_acc && need_push;

  always_comb begin
    q_job.mode      = mode_r;
    q_job.data      = in_data.in_byte;
    q_job.nzero     = nzero;
    q_job.zcol      = zcol;
    q_job.has_field = has_field;
    q_job.field_val = {partial_r[55:0], in_data.in_byte};
    q_job.field_col = cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FIELD;
      colcnt_r  <= 3'd3;
      width0_r  <= 4'd1;
      width1_r  <= 4'd2;
      width2_r  <= 4'd1;
      width3_r  <= 4'd0;
      partial_r <= '0;
      bt_r      <= '0;
      col_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode_r   <= mode_t'(cfg_wdata[1:0]);
          REG_COLCNT: colcnt_r <= cfg_wdata[2:0];
          REG_WIDTH0: width0_r <= cfg_wdata;
          REG_WIDTH1: width1_r <= cfg_wdata;
          REG_WIDTH2: width2_r <= cfg_wdata;
          REG_WIDTH3: width3_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_data.end_of_buffer) begin
          partial_r <= '0;
          bt_r      <= '0;
          col_r     <= '0;
        end else if (mode_r == MODE_FIELD && any) begin
          if (has_field) begin
            partial_r <= '0;
            bt_r      <= '0;
            col_r     <= col_next(cur, cnt);
          end else begin
            partial_r <= {partial_r[55:0], in_data.in_byte};
            bt_r      <= taken[2:0];
            col_r     <= cur;
          end
        end
      end
    end
  end

  assign eob_acc   = in_acc && in_data.end_of_buffer;
  assign state_clr = (col_r == 2'd0) && (bt_r == 3'd0) && (partial_r == 64'd0);

  `PFU_ASSERT(a_eob_restart, eob_acc |=> state_clr, "field state kept after end of buffer")

endmodule

### rtl/core/pfu_queue.sv
// Short job queue between front and back end.
// Depends on pfu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pfu_pkg::job_t    push_job,
  input  logic             pop,
  output pfu_pkg::job_t    head_job,
  output pfu_pkg::q_stat_t q_stat
);
  import pfu_pkg::*;

  job_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]     cnt_r;

  assign q_stat.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_job     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `PFU_NEVER(a_no_overflow, push && q_stat.full, "push into full queue")
  `PFU_NEVER(a_no_underflow, pop && q_stat.empty, "pop from empty queue")

endmodule

### rtl/core/pfu_back.sv
// Back end: expands queued jobs into results, one per cycle unless stalled.
// Depends on pfu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pfu_pkg::job_t    head_job,
  input  pfu_pkg::q_stat_t q_stat,
  output logic             q_pop,
  output logic             out_valid,
  output pfu_pkg::out_t    out_data,
  input  logic             out_stall
);
  import pfu_pkg::*;

  logic [2:0] step_r;
  logic       out_valid_r;
  out_t       out_data_r;

  logic       out_free;
  logic       load;
  logic [2:0] last_idx;
  logic       last;
  logic [2:0] amt;
  logic [7:0] sh;
  out_t       res;

  assign out_free  = !out_valid_r || !out_stall;
  assign load      = out_free && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    unique case (head_job.mode)
      MODE_BIT1:  last_idx = 3'd7;
      MODE_BIT2:  last_idx = 3'd3;
      MODE_BIT4:  last_idx = 3'd1;
      MODE_FIELD: last_idx = {1'b0, head_job.nzero} + {2'b0, head_job.has_field} - 3'd1;
      default:    last_idx = 3'd0;
    endcase
    last = (step_r == last_idx);

    // samples come out most significant first: shift the consumed ones away
    amt = 3'(step_r << head_job.mode);
    sh  = head_job.data << amt;

    res.last_of_item = last;
    res.column       = 2'd0;
    res.value        = '0;
    unique case (head_job.mode)
      MODE_BIT1:  res.value = {63'd0, sh[7]};
      MODE_BIT2:  res.value = {62'd0, sh[7:6]};
      MODE_BIT4:  res.value = {60'd0, sh[7:4]};
      MODE_FIELD: begin
        if (step_r < {1'b0, head_job.nzero}) begin
          res.column = head_job.zcol[step_r[1:0]];
        end else begin
          res.value  = head_job.field_val;
          res.column = head_job.field_col;
        end
      end
      default: ;
    endcase
  end

  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_free) out_valid_r <= !q_stat.empty;
      if (load) step_r <= last ? 3'd0 : step_r + 3'd1;
    end
  end

  `PFU_ASSERT(a_pop_last, q_pop |=> out_valid && out_data.last_of_item, "job retired without last result")
  `PFU_NEVER(a_step_range, !q_stat.empty && step_r > last_idx, "result step beyond job length")

endmodule

### rtl/core/packed_field_unpacker_top.sv
// Packed field unpacker, top level.
// Channels: in_valid/in_stall/in_data carry one byte transaction (byte plus
//   end_of_buffer mark); out_valid/out_stall/out_data carry one unpacked value
//   with its column and a last_of_item flag on the final result of a byte.
// Configuration: cfg_we/cfg_index/cfg_wdata write mode, column count and the
//   four column widths; write only while the block is idle.
// Path: an accepted byte's job is written into the queue, its first result
//   then into the output register; later while earlier results are queued.
// Throughput: the back end gives one result per cycle unless stalled, and
//   a byte yields 1 to 8 results (8 in one-bit mode, 4 two-bit, 2 four-bit,
//   1 to 4 in field mode). A byte that yields no result is not queued.
// The front end takes a byte whenever the two-entry job queue has room, so
//   input keeps flowing while a result waits in the output register.
// Reset (rst_n low, synchronous) restores the register defaults (field mode,
//   three columns of 1, 2, 1 bytes), clears the field state and empties queue
//   and output. When out_stall is high the output holds; the queue then fills
//   and in_stall rises.
// Depends on pfu_pkg, pfu_front, pfu_queue and pfu_back.
module packed_field_unpacker_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [3:0]     cfg_wdata,
  input  logic           in_valid,
  input  pfu_pkg::in_t   in_data,
  output logic           in_stall,
  output logic           out_valid,
  output pfu_pkg::out_t  out_data,
  input  logic           out_stall
);
  import pfu_pkg::*;

  q_stat_t q_stat;
  logic    q_push, q_pop;
  job_t    push_job, head_job;

  pfu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  pfu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  pfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
